// ===== hdl/tcp_pkg.sv =====
package tcp_pkg;

    localparam int MA_W   = 13;
    localparam int TICK_W = 10;
    localparam int CFG_W  = 2;
    localparam int PROD_W = MA_W + TICK_W;

    localparam int RAMP_UP_TICKS   = 1000;
    localparam int HOLD_TICKS      = 1000;
    localparam int RAMP_DOWN_TICKS = 1000;

    localparam int UP_LEN   = (RAMP_UP_TICKS == 0) ? 1 : RAMP_UP_TICKS;
    localparam int HOLD_LEN = (HOLD_TICKS == 0) ? 1 : HOLD_TICKS;
    localparam int DOWN_LEN = (RAMP_DOWN_TICKS == 0) ? 1 : RAMP_DOWN_TICKS;

    localparam logic [TICK_W:0] UP_LEN_V   = (TICK_W + 1)'(UP_LEN);
    localparam logic [TICK_W:0] HOLD_LEN_V = (TICK_W + 1)'(HOLD_LEN);
    localparam logic [TICK_W:0] DOWN_LEN_V = (TICK_W + 1)'(DOWN_LEN);

    localparam int RECIP_SHIFT = PROD_W + TICK_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [RECIP_W-1:0] UP_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(UP_LEN) - 64'd1) / 64'(UP_LEN));
    localparam logic [RECIP_W-1:0] DOWN_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DOWN_LEN) - 64'd1) / 64'(DOWN_LEN));

    localparam logic [MA_W-1:0] RST_STEP   = MA_W'(500);
    localparam logic [MA_W-1:0] RST_MAX    = MA_W'(3000);
    localparam logic [MA_W-1:0] RST_MIN    = MA_W'(500);
    localparam logic [MA_W-1:0] RST_LIMIT  = MA_W'(5000);
    localparam logic [MA_W-1:0] RST_TARGET = MA_W'(1000);

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_HOLD = 2'd1,
        PH_DOWN = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DRV_ZERO = 2'd0,
        DRV_HOLD = 2'd1,
        DRV_UP   = 2'd2,
        DRV_DOWN = 2'd3
    } t_drv_mode;

    typedef enum logic [CFG_W-1:0] {
        CFG_STEP  = 2'd0,
        CFG_MAX   = 2'd1,
        CFG_MIN   = 2'd2,
        CFG_LIMIT = 2'd3
    } t_cfg_idx;

endpackage

// ===== hdl/tcp_drive.sv =====
module tcp_drive (
    input  logic [tcp_pkg::PROD_W-1:0] i_prod,
    input  tcp_pkg::t_drv_mode         i_mode,
    input  logic [tcp_pkg::MA_W-1:0]   i_target,
    input  logic [tcp_pkg::MA_W-1:0]   i_limit,
    output logic [tcp_pkg::MA_W-1:0]   o_drive
);
    import tcp_pkg::*;

    logic [RECIP_W-1:0]        recip;
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [MA_W-1:0]           quot;
    logic [MA_W-1:0]           raw;

    always_comb begin
        recip  = (i_mode == DRV_DOWN) ? DOWN_RECIP : UP_RECIP;
        scaled = (PROD_W + RECIP_W)'(i_prod) * (PROD_W + RECIP_W)'(recip);
        quot   = scaled[RECIP_SHIFT +: MA_W];
        case (i_mode)
            DRV_HOLD: raw = i_target;
            DRV_UP:   raw = quot;
            DRV_DOWN: raw = quot;
            default:  raw = '0;
        endcase
        o_drive = (raw > i_limit) ? i_limit : raw;
    end

endmodule

// ===== hdl/trapezoid_current_profile_core.sv =====
// Trapezoidal current profile generator, one item per control tick.
// Input channel (i_in_valid / o_in_ready): assist enable, start/stop click and
// step click. Output channel (o_out_valid / i_out_ready): drive current in mA,
// phase, running flag and target after the tick.
// The profile state (running, phase, tick, target) updates in the cycle an item
// is accepted, so one item per cycle is taken with no gaps while the output flows.
// The ramp value target * tick / length is formed over two registers: the
// product is stored with the item, then a constant reciprocal multiply and the
// clamp to the output limit feed the output register.
// The result passes the stage register and then the output register. Throughput:
// 1 item per cycle while the receiver takes results, set by the state update
// in the cycle an item is accepted.
// The configuration port writes the step, max, min and limit registers; write
// them only while no item is in flight.
// Reset (synchronous, active low) stops the profile, sets phase ramp up, tick 0,
// target 1000 mA and the configuration to its defaults, and empties both stages.
// When the receiver stalls, the result holds and the internal stage still
// takes one more item before o_in_ready drops.
module trapezoid_current_profile_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcp_pkg::CFG_W-1:0]      i_cfg_idx,
    input  logic [tcp_pkg::MA_W-1:0]       i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_assist_enabled,
    input  logic                           i_toggle_click,
    input  logic                           i_step_click,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcp_pkg::MA_W-1:0]       o_drive_ma,
    output logic [1:0]                     o_profile_phase,
    output logic                           o_is_running,
    output logic [tcp_pkg::MA_W-1:0]       o_target_ma
);
    import tcp_pkg::*;

    logic [MA_W-1:0]   r_cfg_step;
    logic [MA_W-1:0]   r_cfg_max;
    logic [MA_W-1:0]   r_cfg_min;
    logic [MA_W-1:0]   r_cfg_limit;

    logic              r_run;
    t_phase            r_phase;
    logic [TICK_W-1:0] r_tick;
    logic [MA_W-1:0]   r_target;

    logic              n_run;
    t_phase            n_phase;
    logic [TICK_W-1:0] n_tick;
    logic [MA_W-1:0]   n_target;
    logic [PROD_W-1:0] n_prod;

    logic              r_a_vld;
    logic [PROD_W-1:0] r_a_prod;
    t_drv_mode         r_a_mode;
    logic [MA_W-1:0]   r_a_target;
    t_phase            r_a_phase;
    logic              r_a_run;

    logic              r_o_vld;
    logic [MA_W-1:0]   r_o_drive;
    t_phase            r_o_phase;
    logic              r_o_run;
    logic [MA_W-1:0]   r_o_target;

    t_drv_mode         mode;
    logic [TICK_W-1:0] count;
    logic [TICK_W:0]   len;
    logic [TICK_W:0]   tick_inc;
    t_phase            nxt;
    logic              adv;
    logic [MA_W:0]     tgt_sum;
    logic [MA_W-1:0]   drive;

    logic              in_acc;
    logic              o_load;
    logic              o_acc;

    assign o_acc      = r_o_vld && i_out_ready;
    assign o_load     = r_a_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready = !r_a_vld || o_load;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_run    = r_run;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_target = r_target;
        mode     = DRV_ZERO;
        count    = '0;
        len      = UP_LEN_V;
        nxt      = PH_HOLD;
        adv      = 1'b0;
        tick_inc = '0;
        tgt_sum  = {1'b0, r_target} + {1'b0, r_cfg_step};
        if (!i_assist_enabled) begin
            n_run   = 1'b0;
            n_phase = PH_UP;
            n_tick  = '0;
        end else begin
            if (i_toggle_click) begin
                n_run = !r_run;
                if (!r_run) begin
                    n_phase = PH_UP;
                    n_tick  = '0;
                end
            end
            if (i_step_click) begin
                n_target = (tgt_sum > {1'b0, r_cfg_max}) ? r_cfg_min : tgt_sum[MA_W-1:0];
            end
            if (n_run) begin
                case (n_phase)
                    PH_UP: begin
                        mode  = DRV_UP;
                        count = n_tick;
                        len   = UP_LEN_V;
                        nxt   = PH_HOLD;
                        adv   = 1'b1;
                    end
                    PH_HOLD: begin
                        mode = DRV_HOLD;
                        len  = HOLD_LEN_V;
                        nxt  = PH_DOWN;
                        adv  = 1'b1;
                    end
                    PH_DOWN: begin
                        mode  = DRV_DOWN;
                        count = ({1'b0, n_tick} >= DOWN_LEN_V) ? '0 :
                                TICK_W'(DOWN_LEN_V - {1'b0, n_tick});
                        len   = DOWN_LEN_V;
                        nxt   = PH_UP;
                        adv   = 1'b1;
                    end
                    default: begin
                        n_phase = PH_UP;
                        n_tick  = '0;
                    end
                endcase
                if (adv) begin
                    tick_inc = {1'b0, n_tick} + (TICK_W + 1)'(1);
                    if (tick_inc >= len) begin
                        n_phase = nxt;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc[TICK_W-1:0];
                    end
                end
            end
        end
        n_prod = PROD_W'(n_target) * PROD_W'(count);
    end

    tcp_drive u_drive (
        .i_prod   (r_a_prod),
        .i_mode   (r_a_mode),
        .i_target (r_a_target),
        .i_limit  (r_cfg_limit),
        .o_drive  (drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_step  <= RST_STEP;
            r_cfg_max   <= RST_MAX;
            r_cfg_min   <= RST_MIN;
            r_cfg_limit <= RST_LIMIT;
            r_run       <= 1'b0;
            r_phase     <= PH_UP;
            r_tick      <= '0;
            r_target    <= RST_TARGET;
            r_a_vld     <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP:  r_cfg_step  <= i_cfg_wdata;
                    CFG_MAX:   r_cfg_max   <= i_cfg_wdata;
                    CFG_MIN:   r_cfg_min   <= i_cfg_wdata;
                    CFG_LIMIT: r_cfg_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_run    <= n_run;
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_target <= n_target;
            end
            if (in_acc) begin
                r_a_vld <= 1'b1;
            end else if (o_load) begin
                r_a_vld <= 1'b0;
            end
            if (o_load) begin
                r_o_vld <= 1'b1;
            end else if (o_acc) begin
                r_o_vld <= 1'b0;
            end
        end
        if (in_acc) begin
            r_a_prod   <= n_prod;
            r_a_mode   <= mode;
            r_a_target <= n_target;
            r_a_phase  <= n_phase;
            r_a_run    <= n_run;
        end
        if (o_load) begin
            r_o_drive  <= drive;
            r_o_phase  <= r_a_phase;
            r_o_run    <= r_a_run;
            r_o_target <= r_a_target;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_drive_ma      = r_o_drive;
    assign o_profile_phase = r_o_phase;
    assign o_is_running    = r_o_run;
    assign o_target_ma     = r_o_target;

    a_stopped_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_running) |-> (o_drive_ma == '0))
        else $error("drive nonzero while stopped");

    a_drive_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_ma <= r_cfg_limit))
        else $error("drive above output limit");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_a_vld)
        else $error("accepted item lost from stage");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_UP) || (r_phase == PH_HOLD) || (r_phase == PH_DOWN) ||
        (r_tick == '0))
        else $error("fault phase with nonzero tick");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcp_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_GAP     = 30;
    localparam int MAX_STALL   = 24;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [MA_W-1:0] drive_ma;
        logic [1:0]      phase;
        logic            running;
        logic [MA_W-1:0] target_ma;
    } tick_result_t;

    class profile_scoreboard;
        logic [MA_W-1:0] step_ma;
        logic [MA_W-1:0] max_ma;
        logic [MA_W-1:0] min_ma;
        logic [MA_W-1:0] limit_ma;
        logic [MA_W-1:0] target_ma;
        bit              running;
        t_phase          phase;
        int unsigned     phase_ticks;
        tick_result_t    pending_q[$];
        int unsigned     mismatches;

        function new();
            step_ma     = RST_STEP;
            max_ma      = RST_MAX;
            min_ma      = RST_MIN;
            limit_ma    = RST_LIMIT;
            target_ma   = RST_TARGET;
            running     = 1'b0;
            phase       = PH_UP;
            phase_ticks = 0;
            mismatches  = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [MA_W-1:0] value);
            case (idx)
                CFG_STEP:  step_ma  = value;
                CFG_MAX:   max_ma   = value;
                CFG_MIN:   min_ma   = value;
                CFG_LIMIT: limit_ma = value;
                default: ;
            endcase
        endfunction

        function void advance_phase(int unsigned len, t_phase next);
            if (phase_ticks + 1 >= len) begin
                phase       = next;
                phase_ticks = 0;
            end else begin
                phase_ticks = phase_ticks + 1;
            end
        endfunction

        function void note_tick(bit enabled, bit toggle, bit step);
            int unsigned  drive;
            int unsigned  sum;
            int unsigned  tgt;
            tick_result_t r;
            drive = 0;
            if (!enabled) begin
                running     = 1'b0;
                phase       = PH_UP;
                phase_ticks = 0;
            end else begin
                if (toggle) begin
                    running = !running;
                    if (running) begin
                        phase       = PH_UP;
                        phase_ticks = 0;
                    end
                end
                if (step) begin
                    sum       = 32'(target_ma) + 32'(step_ma);
                    target_ma = (sum > 32'(max_ma)) ? min_ma : MA_W'(sum);
                end
                if (running) begin
                    tgt = 32'(target_ma);
                    case (phase)
                        PH_UP: begin
                            drive = tgt * phase_ticks / UP_LEN;
                            advance_phase(UP_LEN, PH_HOLD);
                        end
                        PH_HOLD: begin
                            drive = tgt;
                            advance_phase(HOLD_LEN, PH_DOWN);
                        end
                        default: begin
                            drive = (phase_ticks >= DOWN_LEN) ? 0 :
                                    tgt * (DOWN_LEN - phase_ticks) / DOWN_LEN;
                            advance_phase(DOWN_LEN, PH_UP);
                        end
                    endcase
                    if (drive > 32'(limit_ma)) drive = 32'(limit_ma);
                end
            end
            r.drive_ma  = MA_W'(drive);
            r.phase     = phase;
            r.running   = running;
            r.target_ma = target_ma;
            pending_q.push_back(r);
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (pending_q.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result: drive %0d phase %0d running %0b target %0d",
                             got.drive_ma, got.phase, got.running, got.target_ma);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got.drive_ma !== want.drive_ma || got.phase !== want.phase ||
                got.running !== want.running || got.target_ma !== want.target_ma) begin
                if (mismatches < REPORT_MAX) begin
                    $display("mismatch exp: drive %0d phase %0d running %0b target %0d",
                             want.drive_ma, want.phase, want.running, want.target_ma);
                    $display("         got: drive %0d phase %0d running %0b target %0d",
                             got.drive_ma, got.phase, got.running, got.target_ma);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic            i_clk            = 1'b0;
    logic            i_rst_n          = 1'b0;
    logic            i_cfg_we         = 1'b0;
    t_cfg_idx        i_cfg_idx        = CFG_STEP;
    logic [MA_W-1:0] i_cfg_wdata      = '0;
    logic            i_in_valid       = 1'b0;
    logic            i_assist_enabled = 1'b0;
    logic            i_toggle_click   = 1'b0;
    logic            i_step_click     = 1'b0;
    logic            i_out_ready      = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic [MA_W-1:0] o_drive_ma;
    logic [1:0]      o_profile_phase;
    logic            o_is_running;
    logic [MA_W-1:0] o_target_ma;

    profile_scoreboard sb;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          stall_run     = 0;
    int          ticks_sent    = 0;
    int unsigned cycle_count   = 0;

    trapezoid_current_profile_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_assist_enabled (i_assist_enabled),
        .i_toggle_click   (i_toggle_click),
        .i_step_click     (i_step_click),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_ma       (o_drive_ma),
        .o_profile_phase  (o_profile_phase),
        .o_is_running     (o_is_running),
        .o_target_ma      (o_target_ma)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_drive_ma, o_profile_phase, o_is_running, o_target_ma});
        if (stall_run < MAX_STALL && $urandom_range(99) < stall_pct) begin
            i_out_ready <= 1'b0;
            stall_run++;
        end else begin
            i_out_ready <= 1'b1;
            stall_run = 0;
        end
    end

    task automatic send_tick(bit enabled, bit toggle, bit step);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_assist_enabled <= enabled;
        i_toggle_click   <= toggle;
        i_step_click     <= step;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(enabled, toggle, step);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_registers(logic [MA_W-1:0] step_v, logic [MA_W-1:0] max_v,
                                     logic [MA_W-1:0] min_v, logic [MA_W-1:0] limit_v);
        logic [MA_W-1:0] vals [4];
        vals = '{step_v, max_v, min_v, limit_v};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(k);
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.set_register(t_cfg_idx'(k), vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        bit [2:0] seq [22];
        seq = '{3'b011, 3'b000, 3'b101, 3'b110, 3'b100, 3'b100, 3'b100, 3'b111,
                3'b100, 3'b101, 3'b111, 3'b100, 3'b101, 3'b101, 3'b101, 3'b101,
                3'b000, 3'b010, 3'b110, 3'b100, 3'b001, 3'b000};
        foreach (seq[k]) send_tick(seq[k][2], seq[k][1], seq[k][0]);
    endtask

    // run through ramp up into hold, stop, step past the maximum, then restart
    task automatic run_long_profile();
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        repeat (1050) send_tick(1'b1, 1'b0, $urandom_range(99) == 0);
        send_tick(1'b1, 1'b1, 1'b1);
        repeat (4) send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        repeat (20) send_tick(1'b1, 1'b0, $urandom_range(99) == 0);
        send_tick(1'b0, 1'b1, 1'b1);
    endtask

    task automatic run_session(int len);
        send_tick(1'b1, 1'b1, $urandom_range(9) == 0);
        repeat (len) send_tick(1'b1, $urandom_range(49) == 0, $urandom_range(24) == 0);
        if ($urandom_range(1)) begin
            send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
            send_tick(1'b1, 1'b1, 1'b0);
            repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b0, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(int count, int idle_pct, int stall);
        int goal;
        goal = ticks_sent + count;
        while (ticks_sent < goal) begin
            send_idle_pct = idle_pct;
            stall_pct     = stall;
            if ($urandom_range(3) == 0) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            else
                run_session($urandom_range(4, 60));
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_drained();
        program_registers(MA_W'(700), MA_W'(4000), MA_W'(200), MA_W'(2500));
        run_long_profile();
        wait_drained();
        program_registers(MA_W'(8000), MA_W'(8000), MA_W'(0), MA_W'(8000));
        run_random(120, 74, 0);
        wait_drained();
        program_registers(MA_W'(0), MA_W'(0), MA_W'(8000), MA_W'(0));
        run_random(100, 0, 74);
        wait_drained();
        program_registers(MA_W'($urandom_range(8000)), MA_W'($urandom_range(8000)),
                          MA_W'($urandom_range(8000)), MA_W'($urandom_range(8000)));
        run_random(120, 14, 14);
        wait_drained();
        program_registers(MA_W'(1), MA_W'(8000), MA_W'(8000), MA_W'(4000));
        run_random(110, 74, 0);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
